FILE: design/fwb_pkg.sv
// fwb_pkg: shared types, operation codes and float rounding helpers
// for the float word bitwise unit; no dependencies
`timescale 1ns / 1ps

package fwb_pkg;

	localparam logic [3:0] KIND_AND  = 4'd0;
	localparam logic [3:0] KIND_OR   = 4'd1;
	localparam logic [3:0] KIND_XOR  = 4'd2;
	localparam logic [3:0] KIND_NOT  = 4'd3;
	localparam logic [3:0] KIND_SHL  = 4'd4;
	localparam logic [3:0] KIND_LSR  = 4'd5;
	localparam logic [3:0] KIND_ASR  = 4'd6;
	localparam logic [3:0] KIND_ROTL = 4'd7;
	localparam logic [3:0] KIND_ROTR = 4'd8;

	localparam logic DEFAULT_FIXED_MODE = 1'b0;

	// word and wide-value sign flag handed to the back conversion
	typedef struct packed {
		logic [31:0] word;
		logic        flag;
		logic        fx;
	} word_item_t;

	// position of the highest set bit
	function automatic logic [5:0] msb_pos(input logic [32:0] x);
		logic [5:0] p;
		p = 6'd0;
		for (int i = 0; i < 33; i++) begin
			if (x[i]) p = 6'(i);
		end
		return p;
	endfunction

	// round an integer to 24 significant bits, nearest even
	function automatic logic [32:0] round24(input logic [32:0] x);
		logic [5:0]  p;
		logic [5:0]  k;
		logic [32:0] lowmask;
		logic [32:0] half;
		logic [32:0] rem;
		logic [32:0] unit;
		logic        inc;
		p = msb_pos(x);
		if (p <= 6'd23) begin
			return x;
		end
		k = p - 6'd23;
		unit = 33'd1 << k;
		lowmask = unit - 33'd1;
		half = unit >> 1;
		rem = x & lowmask;
		inc = (rem > half) || ((rem == half) && ((x & unit) != 33'd0));
		return (x & ~lowmask) + (inc ? unit : 33'd0);
	endfunction

	// exact encode of an integer with at most 24 significant bits
	function automatic logic [31:0] encode(input logic [32:0] x, input logic sign,
		input logic fx);
		logic [5:0]  p;
		logic [32:0] y;
		logic [7:0]  e;
		p = msb_pos(x);
		y = x << (6'd32 - p);
		e = 8'(8'd127 + 8'(p) - (fx ? 8'd16 : 8'd0));
		if (x == 33'd0) begin
			return 32'h0;
		end
		return {sign, e, y[31:9]};
	endfunction

endpackage

FILE: design/fwb_word_op.sv
// fwb_word_op: float32 operands to words, then the bitwise, shift or rotate
// operation; uses fwb_pkg
`timescale 1ns / 1ps

module fwb_word_op (
	input  logic [3:0]          kind,
	input  logic [31:0]         operand_a,
	input  logic [31:0]         operand_b,
	input  logic                fx,
	output fwb_pkg::word_item_t item
);

	typedef struct packed {
		logic        nan;
		logic        sign;
		logic        nonzero;
		logic        big;
		logic        neg_2p32;
		logic [31:0] ip;
		logic        fracnz;
	} floor_t;

	function automatic floor_t split(input logic [31:0] bits, input logic sc);
		floor_t      r;
		logic [7:0]  ex;
		logic [23:0] m;
		logic signed [9:0] ee;
		logic [54:0] t;
		ex = bits[30:23];
		m = (ex == 8'd0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
		ee = $signed({2'b00, ((ex == 8'd0) ? 8'd1 : ex)}) - 10'sd127
			+ (sc ? 10'sd16 : 10'sd0);
		r.nan = (ex == 8'hFF) && (bits[22:0] != 23'd0);
		r.sign = bits[31];
		r.nonzero = (bits[30:0] != 31'd0);
		r.big = (ee >= 10'sd32);
		r.neg_2p32 = (ee == 10'sd32) && (m == 24'h800000);
		if (ee < 10'sd0) begin
			r.ip = 32'd0;
			r.fracnz = (m != 24'd0);
		end else begin
			t = {31'd0, m} << ee[4:0];
			r.ip = t[54:23];
			r.fracnz = |t[22:0];
		end
		return r;
	endfunction

	function automatic logic [32:0] to_word(input logic [31:0] bits, input logic sc);
		floor_t      s;
		logic [31:0] w;
		s = split(bits, sc);
		if (s.nan) begin
			w = 32'd0;
		end else if (s.big) begin
			w = !s.sign ? 32'hFFFFFFFF : (s.neg_2p32 ? 32'd0 : 32'h80000000);
		end else if (s.sign) begin
			w = 32'(33'd0 - ({1'b0, s.ip} + {32'd0, s.fracnz}));
		end else begin
			w = s.ip;
		end
		return {w, !s.nan && s.sign && s.nonzero};
	endfunction

	logic [32:0] wa;
	logic [32:0] wb;
	floor_t      cnt;
	logic [32:0] cnt_val;
	logic        cnt_neg;
	logic [6:0]  n;
	logic [3:0]  eff;
	logic [31:0] x;
	logic        fl;

	assign wa = to_word(operand_a, fx);
	assign wb = to_word(operand_b, fx);
	assign cnt = split(operand_b, 1'b0);
	assign cnt_val = {1'b0, cnt.ip} + {32'd0, cnt.sign & cnt.fracnz};
	assign cnt_neg = !cnt.nan && cnt.sign && (cnt_val != 33'd0);

	always_comb begin
		if (cnt.nan) begin
			n = 7'd0;
		end else if (cnt.big || cnt_val >= 33'd64) begin
			n = 7'd64;
		end else begin
			n = cnt_val[6:0];
		end
		eff = kind;
		if (cnt_neg) begin
			case (kind)
				fwb_pkg::KIND_SHL:  eff = fx ? fwb_pkg::KIND_ASR : fwb_pkg::KIND_LSR;
				fwb_pkg::KIND_LSR:  eff = fwb_pkg::KIND_SHL;
				fwb_pkg::KIND_ASR:  eff = fwb_pkg::KIND_SHL;
				fwb_pkg::KIND_ROTL: eff = fwb_pkg::KIND_ROTR;
				fwb_pkg::KIND_ROTR: eff = fwb_pkg::KIND_ROTL;
				default:            eff = kind;
			endcase
		end
		x = wa[32:1];
		fl = wa[0];
		case (eff)
			fwb_pkg::KIND_AND: begin
				x = wa[32:1] & wb[32:1];
				fl = wa[0] & wb[0];
			end
			fwb_pkg::KIND_OR: begin
				x = wa[32:1] | wb[32:1];
				fl = wa[0] | wb[0];
			end
			fwb_pkg::KIND_XOR: begin
				x = wa[32:1] ^ wb[32:1];
				fl = wa[0] ^ wb[0];
			end
			fwb_pkg::KIND_NOT: begin
				x = ~wa[32:1];
				fl = !wa[0];
			end
			fwb_pkg::KIND_SHL: begin
				if (n >= 7'd32) begin
					x = 32'd0;
					fl = 1'b0;
				end else begin
					x = wa[32:1] << n[4:0];
				end
			end
			fwb_pkg::KIND_LSR: begin
				if (n != 7'd0) fl = 1'b0;
				x = (n >= 7'd32) ? 32'd0 : (wa[32:1] >> n[4:0]);
			end
			fwb_pkg::KIND_ASR: begin
				if (n >= 7'd32) begin
					x = {32{wa[32]}};
				end else begin
					x = 32'($signed(wa[32:1]) >>> n[4:0]);
				end
			end
			fwb_pkg::KIND_ROTL: begin
				x = (wa[32:1] << n[4:0]) | (wa[32:1] >> (6'd32 - {1'b0, n[4:0]}));
			end
			fwb_pkg::KIND_ROTR: begin
				x = (wa[32:1] >> n[4:0]) | (wa[32:1] << (6'd32 - {1'b0, n[4:0]}));
			end
			default: begin
				x = wa[32:1];
				fl = wa[0];
			end
		endcase
	end

	assign item.word = x;
	assign item.flag = fl;
	assign item.fx = fx;

endmodule

FILE: design/fwb_to_float.sv
// fwb_to_float: two-stage word to float32 conversion with the 2^32 wrap
// correction and 16.16 scaling; uses fwb_pkg
`timescale 1ns / 1ps

module fwb_to_float (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  fwb_pkg::word_item_t item,
	output logic                out_valid,
	output logic [31:0]         out_bits
);

	logic        top;
	logic [32:0] mag;
	logic        v_s3;
	logic [32:0] r_s3;
	logic        top_s3;
	logic        fix_s3;
	logic        fx_s3;
	logic [32:0] d;
	logic [31:0] f;

	assign top = item.word[31];
	assign mag = top ? {1'b0, 32'(32'd0 - item.word)} : {1'b0, item.word};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		r_s3 <= fwb_pkg::round24(mag);
		top_s3 <= top;
		fix_s3 <= !item.fx && (top != item.flag);
		fx_s3 <= item.fx;
	end

	// rounded magnitude moved across 2^32, rounded once more
	assign d = 33'h100000000 - r_s3;

	always_comb begin
		if (fix_s3) begin
			f = fwb_pkg::encode(fwb_pkg::round24(d), !top_s3, 1'b0);
		end else begin
			f = fwb_pkg::encode(r_s3, top_s3, fx_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		out_bits <= f;
	end

endmodule

FILE: design/float_word_bitwise_unit_core.sv
// float_word_bitwise_unit_core: top level of the float word bitwise unit
// depends on fwb_pkg, fwb_word_op and fwb_to_float
`timescale 1ns / 1ps

//  channel   signals                               direction  transfer when
//  command   start, busy, kind, operand_a/b        in         start && !busy
//  result    done, result                          out        done (one cycle)
//  config    cfg_valid, cfg_ready, cfg_data        in         cfg_valid && cfg_ready
//
//  one command per cycle; each result passes through the input register, the
//  operation stage and two rounding stages of the float conversion
//  busy stays low: the pipeline never holds a command back
//  the receiver cannot stall, results leave on done without backpressure
//  asynchronous reset clears valid bits and loads the mode register with FIXED_MODE_RESET

module float_word_bitwise_unit_core #(
	parameter logic FIXED_MODE_RESET = fwb_pkg::DEFAULT_FIXED_MODE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  kind,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        done,
	output logic [31:0] result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	// mode register
	logic fixed_mode_q;

	// input register
	logic        v_s1;
	logic [3:0]  kind_s1;
	logic [31:0] a_s1;
	logic [31:0] b_s1;
	logic        fx_s1;

	// operation result
	fwb_pkg::word_item_t item_c;
	fwb_pkg::word_item_t item_s2;
	logic                v_s2;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_mode_q <= FIXED_MODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			fixed_mode_q <= cfg_data;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
		end
	end

	// payload, mode travels with each command
	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		a_s1 <= operand_a;
		b_s1 <= operand_b;
		fx_s1 <= fixed_mode_q;
	end

	fwb_word_op u_word_op (
		.kind      (kind_s1),
		.operand_a (a_s1),
		.operand_b (b_s1),
		.fx        (fx_s1),
		.item      (item_c)
	);

	always_ff @(posedge clk) begin
		item_s2 <= item_c;
	end

	fwb_to_float u_to_float (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.item      (item_s2),
		.out_valid (done),
		.out_bits  (result)
	);

	// every result comes from an earlier command on start
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result without a command");

	// a zero word with clear flag always comes back as plus zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && item_s2.word == 32'd0 && !item_s2.flag) |-> ##2 (done && result == 32'h0))
		else $error("zero word not returned as zero");

	// a stage-two item always reaches the result port
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ##2 done)
		else $error("item lost in conversion");

endmodule

FILE: bench/float_word_bitwise_unit_core_test.sv
// float_word_bitwise_unit_core_test: self-checking bench for the float word bitwise unit
// depends on fwb_pkg and float_word_bitwise_unit_core; predicts results in exact integer math
`timescale 1ns / 1ps

module float_word_bitwise_unit_core_test;

	localparam logic MODE_INT   = 1'b0;
	localparam logic MODE_FIXED = 1'b1;
	localparam int   PIPE_DRAIN = 8;
	localparam int   CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] a;
		logic [31:0] b;
	} command_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [3:0]  kind;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	logic        done;
	logic [31:0] result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	command_t    pending_cmds[$];
	logic [31:0] expected_floats[$];
	logic        fixed_mode;
	int          error_count;
	int          cycle_count;
	int          burst_left;
	int          gap_left;

	float_word_bitwise_unit_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// prediction, all in exact integer math so no float rounding of
	// the simulator itself leaks in
	// ---------------------------------------------------------------

	function automatic int top_bit(input logic [39:0] x);
		int p;
		p = 0;
		for (int i = 0; i < 40; i++) begin
			if (x[i]) p = i;
		end
		return p;
	endfunction

	// round a magnitude to 24 significant bits, nearest even, keeping the scale
	function automatic logic [39:0] round_mag(input logic [39:0] m);
		int          p;
		logic [39:0] unit;
		logic [39:0] rem;
		logic [39:0] q;
		p = top_bit(m);
		if (p <= 23) return m;
		unit = 40'd1 << (p - 23);
		rem = m & (unit - 40'd1);
		q = m & ~(unit - 40'd1);
		if (rem > (unit >> 1) || (rem == (unit >> 1) && (m & unit) != 40'd0))
			q = q + unit;
		return q;
	endfunction

	// pack a magnitude that already fits in 24 significant bits
	function automatic logic [31:0] pack_float(input logic sgn, input logic [39:0] m,
		input logic fx);
		int          p;
		logic [39:0] mant;
		logic [7:0]  e;
		if (m == 40'd0) return 32'h0;
		p = top_bit(m);
		mant = (p > 23) ? (m >> (p - 23)) : (m << (23 - p));
		e = 8'(127 + p - (fx ? 16 : 0));
		return {sgn, e, mant[22:0]};
	endfunction

	// floor of the float value, optionally scaled by 2^16; infinities and huge
	// values land on +-2^70 which is far past every clamp used later
	function automatic logic signed [71:0] floor_value(input logic [31:0] bits,
		input logic scale);
		logic        sgn;
		logic [7:0]  e;
		logic [71:0] sig;
		logic [71:0] ip;
		logic [71:0] mag;
		int          ex;
		int          sh;
		sgn = bits[31];
		e = bits[30:23];
		sig = (e == 8'd0) ? {48'd0, 1'b0, bits[22:0]} : {48'd0, 1'b1, bits[22:0]};
		ex = ((e == 8'd0) ? -149 : int'(e) - 150) + (scale ? 16 : 0);
		if (e == 8'hFF || ex > 40) begin
			mag = 72'd1 << 70;
			return sgn ? -$signed(mag) : $signed(mag);
		end
		if (ex >= 0) begin
			mag = sig << ex;
			return sgn ? -$signed(mag) : $signed(mag);
		end
		sh = -ex;
		ip = sig >> sh;
		// negative values with a fraction floor one step further down
		if (sgn && ((ip << sh) != sig)) ip = ip + 72'd1;
		return sgn ? -$signed(ip) : $signed(ip);
	endfunction

	function automatic logic is_nan(input logic [31:0] bits);
		return bits[30:23] == 8'hFF && bits[22:0] != 23'd0;
	endfunction

	// operand to word, with saturation beyond +-2^32 and wrap inside it
	function automatic logic [31:0] operand_word(input logic [31:0] bits, input logic fx);
		logic signed [71:0] v;
		if (is_nan(bits)) return 32'h0;
		v = floor_value(bits, fx);
		if (v >= 72'sd4294967296) return 32'hFFFF_FFFF;
		if (v < -72'sd4294967296) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// set where the wide value is strictly negative (minus zero and nan are not)
	function automatic logic operand_negative(input logic [31:0] bits);
		return !is_nan(bits) && bits[31] && bits[30:0] != 31'd0;
	endfunction

	function automatic int shift_count(input logic [31:0] bits);
		logic signed [71:0] v;
		if (is_nan(bits)) return 0;
		v = floor_value(bits, 1'b0);
		if (v > 72'sd64) return 64;
		if (v < -72'sd64) return -64;
		return int'(v);
	endfunction

	function automatic logic [31:0] word_to_float(input logic [31:0] w, input logic neg,
		input logic fx);
		logic        top;
		logic [39:0] rs;
		top = w[31];
		rs = round_mag(top ? {8'd0, -w} : {8'd0, w});
		if (fx) return pack_float(top, rs, 1'b1);
		// wide sign disagrees with bit 31: shift the value by 2^32, rounding again
		if (top != neg) return pack_float(!top, round_mag(40'h1_0000_0000 - rs), 1'b0);
		return pack_float(top, rs, 1'b0);
	endfunction

	function automatic logic [31:0] bitwise_float_result(input command_t c, input logic fx);
		logic [31:0] x;
		logic [31:0] y;
		logic        ha;
		logic        hb;
		logic [3:0]  op;
		int          n;
		x = operand_word(c.a, fx);
		ha = operand_negative(c.a);
		op = c.kind;
		if (op <= fwb_pkg::KIND_NOT) begin
			y = operand_word(c.b, fx);
			hb = operand_negative(c.b);
			case (op)
				fwb_pkg::KIND_AND: begin x = x & y; ha = ha & hb; end
				fwb_pkg::KIND_OR:  begin x = x | y; ha = ha | hb; end
				fwb_pkg::KIND_XOR: begin x = x ^ y; ha = ha ^ hb; end
				default:           begin x = ~x;    ha = !ha;    end
			endcase
		end else if (op <= fwb_pkg::KIND_ROTR) begin
			n = shift_count(c.b);
			// negative counts turn the shift around
			if (n < 0) begin
				n = -n;
				case (op)
					fwb_pkg::KIND_SHL:
						op = fx ? fwb_pkg::KIND_ASR : fwb_pkg::KIND_LSR;
					fwb_pkg::KIND_LSR, fwb_pkg::KIND_ASR: op = fwb_pkg::KIND_SHL;
					fwb_pkg::KIND_ROTL: op = fwb_pkg::KIND_ROTR;
					default:            op = fwb_pkg::KIND_ROTL;
				endcase
			end
			case (op)
				fwb_pkg::KIND_SHL: begin
					if (n >= 32) begin x = 32'h0; ha = 1'b0; end
					else x = x << n;
				end
				fwb_pkg::KIND_LSR: begin
					if (n > 0) ha = 1'b0;
					x = (n >= 32) ? 32'h0 : x >> n;
				end
				fwb_pkg::KIND_ASR: x = (n >= 32) ? {32{x[31]}} : 32'($signed(x) >>> n);
				fwb_pkg::KIND_ROTL: begin
					n = n & 31;
					if (n != 0) x = (x << n) | (x >> (32 - n));
				end
				default: begin
					n = n & 31;
					if (n != 0) x = (x >> n) | (x << (32 - n));
				end
			endcase
		end
		// unused kinds pass operand a through
		return word_to_float(x, ha, fx);
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	function automatic logic [31:0] random_operand();
		logic [7:0] e;
		case ($urandom_range(0, 9))
			0, 1: return $urandom();
			2: begin
				// a handful of hand-picked edges: zeros, +-2^31, +-2^32, inf, nan
				case ($urandom_range(0, 7))
					0: return 32'h0000_0000;
					1: return 32'h8000_0000;
					2: return 32'h4F00_0000;
					3: return 32'hCF00_0000;
					4: return 32'h4F80_0000;
					5: return 32'hCF80_0000;
					6: return {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
					default: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 8388607))};
				endcase
			end
			default: begin
				// values between about 2^-17 and 2^33, where the word is interesting
				e = 8'($urandom_range(110, 160));
				return {$urandom_range(0, 1) == 1, e, 23'($urandom())};
			end
		endcase
	endfunction

	// small shift counts, fractional and negative ones included
	function automatic logic [31:0] random_count();
		if ($urandom_range(0, 7) == 0) return random_operand();
		return {$urandom_range(0, 1) == 1, 8'($urandom_range(120, 134)), 23'($urandom())};
	endfunction

	function automatic command_t random_command();
		command_t c;
		c.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(0, 8));
		c.a = random_operand();
		c.b = (c.kind >= fwb_pkg::KIND_SHL && c.kind <= fwb_pkg::KIND_ROTR)
			? random_count() : random_operand();
		return c;
	endfunction

	task automatic queue_command(input logic [3:0] k, input logic [31:0] a,
		input logic [31:0] b);
		command_t c;
		c.kind = k;
		c.a = a;
		c.b = b;
		pending_cmds.push_back(c);
	endtask

	// directed commands: field extremes, every kind, and the count corner cases
	task automatic queue_directed();
		queue_command(fwb_pkg::KIND_AND,  32'h3F80_0000, 32'hBF80_0000);
		queue_command(fwb_pkg::KIND_OR,   32'hCF80_0000, 32'h4F80_0000);
		queue_command(fwb_pkg::KIND_XOR,  32'h4F00_0000, 32'hCF00_0000);
		queue_command(fwb_pkg::KIND_NOT,  32'h0000_0000, 32'hFFFF_FFFF);
		queue_command(fwb_pkg::KIND_NOT,  32'h8000_0000, 32'h0000_0000);
		queue_command(fwb_pkg::KIND_AND,  32'h7FC0_0000, 32'h7F80_0000);
		queue_command(fwb_pkg::KIND_OR,   32'hFF80_0000, 32'h0000_0001);
		queue_command(fwb_pkg::KIND_XOR,  32'h7F7F_FFFF, 32'hBF00_0000);
		queue_command(fwb_pkg::KIND_SHL,  32'h3F80_0000, 32'h41F8_0000);
		queue_command(fwb_pkg::KIND_SHL,  32'h3F80_0000, 32'h4200_0000);
		queue_command(fwb_pkg::KIND_SHL,  32'hBF80_0000, 32'hBF80_0000);
		queue_command(fwb_pkg::KIND_LSR,  32'hBF80_0000, 32'h3F80_0000);
		queue_command(fwb_pkg::KIND_LSR,  32'hBF80_0000, 32'h0000_0000);
		queue_command(fwb_pkg::KIND_LSR,  32'h4F00_0000, 32'hC200_0000);
		queue_command(fwb_pkg::KIND_ASR,  32'hC2C8_0000, 32'h4280_0000);
		queue_command(fwb_pkg::KIND_ASR,  32'hC2C8_0000, 32'hBFC0_0000);
		queue_command(fwb_pkg::KIND_ROTL, 32'h4F00_0000, 32'h42C8_0000);
		queue_command(fwb_pkg::KIND_ROTL, 32'hBF80_0000, 32'hC2C8_0000);
		queue_command(fwb_pkg::KIND_ROTR, 32'h3F80_0000, 32'h3FC0_0000);
		queue_command(fwb_pkg::KIND_ROTR, 32'h3F80_0000, 32'hC200_0000);
		queue_command(fwb_pkg::KIND_SHL,  32'h3F80_0000, 32'h7FC0_0000);
		queue_command(4'd15,              32'hCF80_0001, 32'h0000_0000);
		queue_command(4'd9,               32'h4F80_0001, 32'hFFFF_FFFF);
	endtask

	// mode changes only with the pipeline empty
	task automatic wait_idle();
		while (pending_cmds.size() != 0 || expected_floats.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		fixed_mode = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic report_mismatch(input command_t c, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch: kind %0d a %h b %h mode %0b: result %h, expected %h",
			c.kind, c.a, c.b, fixed_mode, got, want);
		error_count++;
	endtask

	// ---------------------------------------------------------------
	// driver: bursts of commands with random gaps, changed on the falling edge
	// ---------------------------------------------------------------

	command_t   issued_cmds[$];

	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_cmds.size() != 0) begin
			start <= 1'b1;
			kind <= pending_cmds[0].kind;
			operand_a <= pending_cmds[0].a;
			operand_b <= pending_cmds[0].b;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 24);
				// one burst in four runs straight into the next
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			start <= 1'b0;
		end
	end

	// command transfer: predict the result at the moment it is taken
	always @(posedge clk) begin
		if (arst_n && start && !busy && pending_cmds.size() != 0) begin
			expected_floats.push_back(bitwise_float_result(pending_cmds[0], fixed_mode));
			issued_cmds.push_back(pending_cmds[0]);
			void'(pending_cmds.pop_front());
		end
	end

	// ---------------------------------------------------------------
	// monitor: every done pulse is one result transfer
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_floats.size() == 0) begin
				$display("mismatch: unexpected result %h", result);
				error_count++;
			end else begin
				if (result !== expected_floats[0])
					report_mismatch(issued_cmds[0], result, expected_floats[0]);
				void'(expected_floats.pop_front());
				void'(issued_cmds.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// run sequence: integer mode, fixed mode, back to integer mode
	// ---------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = fwb_pkg::KIND_AND;
		operand_a = 32'h0;
		operand_b = 32'h0;
		cfg_valid = 1'b0;
		cfg_data = MODE_INT;
		fixed_mode = MODE_INT;
		error_count = 0;
		cycle_count = 0;
		burst_left = 8;
		gap_left = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		write_mode(MODE_INT);
		queue_directed();
		repeat (160) pending_cmds.push_back(random_command());
		wait_idle();

		write_mode(MODE_FIXED);
		queue_directed();
		repeat (160) pending_cmds.push_back(random_command());
		wait_idle();

		write_mode(MODE_INT);
		repeat (60) pending_cmds.push_back(random_command());
		wait_idle();

		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
